// ===== design/swhfd_pkg.sv =====
// Package with the shared types and constants of the single-wire humidity frame decoder.
package swhfd_pkg;

    localparam int unsigned EdgeCountWidth = 6;
    localparam int unsigned TimeWidth      = 32;
    localparam int unsigned ThresholdWidth = 16;
    localparam int unsigned FrameWidth     = 40;
    localparam int unsigned OutDataWidth   = 40;
    localparam int unsigned QueueDepth     = 2;

    localparam logic [EdgeCountWidth-1:0] FirstDataEdge = 6'd3;
    localparam logic [EdgeCountWidth-1:0] LastEdge      = 6'd42;
    localparam logic [EdgeCountWidth-1:0] DoneCount     = 6'd43;

    localparam logic [ThresholdWidth-1:0] ThresholdReset = 16'd110;

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_START = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_SHIFT = 2'd1,
        KIND_LAST  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  data_bit;
    } t_cmd;

endpackage

// ===== design/swhfd_front.sv =====
// Front end: accepts items, counts edges, measures intervals and classifies each edge.
module swhfd_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [swhfd_pkg::TimeWidth-1:0]       i_s_tdata,
    input  logic                                  i_s_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [swhfd_pkg::ThresholdWidth-1:0]  i_cfg_data,
    input  logic                                  i_queue_full,
    output logic                                  o_push,
    output swhfd_pkg::t_cmd                       o_push_cmd
);
    import swhfd_pkg::*;

    logic [EdgeCountWidth-1:0] r_edge_count;
    logic [EdgeCountWidth-1:0] n_edge_count;
    logic [TimeWidth-1:0]      r_prev_time;
    logic [TimeWidth-1:0]      n_prev_time;
    logic [ThresholdWidth-1:0] r_threshold;
    logic [TimeWidth-1:0]      interval;
    logic                      accept;

    assign o_s_tready  = !i_queue_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && o_s_tready;
    assign interval    = i_s_tdata - r_prev_time;

    always_comb begin
        n_edge_count        = r_edge_count;
        n_prev_time         = r_prev_time;
        o_push              = 1'b0;
        o_push_cmd.kind     = KIND_SHIFT;
        o_push_cmd.data_bit = (interval > {{(TimeWidth-ThresholdWidth){1'b0}}, r_threshold});
        if (accept) begin
            if (t_opcode'(i_s_tuser) == OP_START) begin
                n_edge_count    = '0;
                o_push          = 1'b1;
                o_push_cmd.kind = KIND_START;
            end else if (r_edge_count < DoneCount) begin
                n_edge_count = r_edge_count + 1'b1;
                n_prev_time  = i_s_tdata;
                if (r_edge_count >= FirstDataEdge) begin
                    o_push          = 1'b1;
                    o_push_cmd.kind = (r_edge_count == LastEdge) ? KIND_LAST : KIND_SHIFT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_prev_time  <= '0;
            r_threshold  <= ThresholdReset;
        end else begin
            r_edge_count <= n_edge_count;
            r_prev_time  <= n_prev_time;
            if (i_cfg_valid && o_cfg_ready) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_count <= DoneCount)
        else $error("edge count passed its saturation value");
`endif

endmodule

// ===== design/swhfd_queue.sv =====
// Short command queue between the front end and the frame assembler.
module swhfd_queue #(
    parameter int unsigned DEPTH = swhfd_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  swhfd_pkg::t_cmd i_push_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output swhfd_pkg::t_cmd o_head
);
    import swhfd_pkg::*;

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

    t_cmd                r_mem [DEPTH];
    logic [PtrWidth-1:0] r_wr_ptr;
    logic [PtrWidth-1:0] r_rd_ptr;
    logic [CntWidth-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == FullCount);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastSlot) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastSlot) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from an empty queue");
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCount)
        else $error("queue count exceeds its depth");
`endif

endmodule

// ===== design/swhfd_back.sv =====
// Back end: shifts data bits into the frame and forms the result item on the last edge.
module swhfd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  swhfd_pkg::t_cmd                     i_head,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [swhfd_pkg::OutDataWidth-1:0]  o_m_tdata,
    output logic                                o_m_tuser
);
    import swhfd_pkg::*;

    logic [FrameWidth-1:0]   r_frame;
    logic [FrameWidth-1:0]   n_frame;
    logic                    r_out_valid;
    logic [OutDataWidth-1:0] r_out_data;
    logic                    r_out_ok;
    logic                    slot_free;
    logic [7:0]              b0;
    logic [7:0]              b1;
    logic [7:0]              b2;
    logic [7:0]              b3;
    logic [7:0]              b4;
    logic [15:0]             magnitude;
    logic [15:0]             temperature;
    logic [7:0]              byte_sum;

    assign slot_free = !r_out_valid || i_m_tready;
    assign o_pop     = !i_empty && ((i_head.kind != KIND_LAST) || slot_free);

    always_comb begin
        case (i_head.kind)
            KIND_START: n_frame = '0;
            KIND_SHIFT,
            KIND_LAST:  n_frame = {r_frame[FrameWidth-2:0], i_head.data_bit};
            default:    n_frame = r_frame;
        endcase
    end

    assign b0          = n_frame[39:32];
    assign b1          = n_frame[31:24];
    assign b2          = n_frame[23:16];
    assign b3          = n_frame[15:8];
    assign b4          = n_frame[7:0];
    assign magnitude   = {1'b0, b2[6:0], b3};
    assign temperature = b2[7] ? (16'd0 - magnitude) : magnitude;
    assign byte_sum    = b0 + b1 + b2 + b3;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= n_frame;
        end
        if (o_pop && (i_head.kind == KIND_LAST)) begin
            r_out_data <= {b4, temperature, b0, b1};
            r_out_ok   <= (byte_sum == b4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && (i_head.kind == KIND_LAST)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ok;

`ifndef NO_ASSERTIONS
    a_last_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_head.kind == KIND_LAST)) |-> slot_free)
        else $error("result formed while the output register still holds an item");
`endif

endmodule

// ===== design/single_wire_humidity_frame_decoder.sv =====
// Top level of the single-wire humidity frame decoder.
// With an empty queue, the edge item that completes the frame is first written into the queue and
// the result item is then formed from it and registered in the back end's output register.
// Throughput: one input item per cycle; the front end stalls only when the queue is full.
// The queue decouples edge measurement from frame assembly, so a stalled output
// holds the back end while the front end keeps taking items until the queue fills.
// Reset is synchronous and active low; it clears counts and sets the threshold to 110.
module single_wire_humidity_frame_decoder #(
    parameter int unsigned QUEUE_DEPTH = swhfd_pkg::QueueDepth
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [swhfd_pkg::TimeWidth-1:0]      i_s_tdata,   // edge_time
    input  logic                                 i_s_tuser,   // opcode
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [swhfd_pkg::ThresholdWidth-1:0] i_cfg_data,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // humidity, temperature, checksum_byte
    output logic [swhfd_pkg::OutDataWidth-1:0]   o_m_tdata,
    output logic                                 o_m_tuser    // checksum_ok
);
    import swhfd_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic pop;
    logic queue_full;
    logic queue_empty;
    t_cmd head;

    swhfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_cmd   (push_cmd)
    );

    swhfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_empty    (queue_empty),
        .o_head     (head)
    );

    swhfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (queue_empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== bench/single_wire_humidity_frame_decoder_test.sv =====
// Self-checking testbench for the single-wire humidity frame decoder, with random edge streams.
`timescale 1ns / 100ps

module single_wire_humidity_frame_decoder_test;

    import swhfd_pkg::*;

    localparam int SettleCycles = 20;
    localparam int MaxReports   = 10;

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_CONFIG,
        ACT_DRAIN
    } t_action;

    typedef struct {
        t_action                   action;
        t_opcode                   opcode;
        logic [TimeWidth-1:0]      edge_time;
        logic [ThresholdWidth-1:0] threshold;
    } t_request;

    typedef struct {
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic [7:0]  checksum_byte;
        logic        checksum_ok;
    } t_reading;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [TimeWidth-1:0]      i_s_tdata = '0;
    logic                      i_s_tuser = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [ThresholdWidth-1:0] i_cfg_data = '0;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [OutDataWidth-1:0]   o_m_tdata;
    logic                      o_m_tuser;

    t_request pending_requests[$];
    t_reading expected_readings[$];

    logic [EdgeCountWidth-1:0] model_edges = '0;
    logic [TimeWidth-1:0]      model_prev_time = '0;
    logic [FrameWidth-1:0]     model_bits = '0;
    logic [ThresholdWidth-1:0] model_threshold = ThresholdReset;

    bit drv_busy = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int send_gap = 0;
    int quiet_cycles = 0;
    int recv_stall = 0;
    int mismatch_count = 0;
    int items_sent = 0;
    int readings_checked = 0;
    int thresholds_written = 0;

    logic [TimeWidth-1:0]      gen_time = '0;
    logic [ThresholdWidth-1:0] gen_thr = ThresholdReset;
    int                        gen_items = 0;
    int                        gen_frames = 0;

    single_wire_humidity_frame_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic void decode_edge(input t_opcode op, input logic [TimeWidth-1:0] stamp);
        logic [TimeWidth-1:0] interval;
        logic [7:0]           b0, b1, b2, b3, b4, sum8;
        logic [15:0]          magnitude;
        t_reading             r;
        if (op == OP_START) begin
            model_edges = '0;
            model_bits  = '0;
            return;
        end
        if (model_edges >= DoneCount) return;
        if (model_edges >= FirstDataEdge) begin
            interval   = stamp - model_prev_time;
            model_bits = {model_bits[FrameWidth-2:0], interval > {16'd0, model_threshold}};
        end
        model_prev_time = stamp;
        if (model_edges == LastEdge) begin
            {b0, b1, b2, b3, b4} = model_bits;
            magnitude       = {1'b0, b2[6:0], b3};
            sum8            = b0 + b1 + b2 + b3;
            r.humidity      = {b0, b1};
            r.temperature   = b2[7] ? 16'd0 - magnitude : magnitude;
            r.checksum_byte = b4;
            r.checksum_ok   = (sum8 == b4);
            expected_readings.push_back(r);
        end
        model_edges = model_edges + 1'b1;
    endfunction

    // Sender: works through the pending requests, one handshake at a time.
    always @(posedge i_clk) begin
        t_request                  head;
        logic                      nxt_valid, nxt_user, nxt_cfg_valid;
        logic [TimeWidth-1:0]      nxt_data;
        logic [ThresholdWidth-1:0] nxt_cfg_data;
        nxt_valid     = i_s_tvalid;
        nxt_user      = i_s_tuser;
        nxt_data      = i_s_tdata;
        nxt_cfg_valid = i_cfg_valid;
        nxt_cfg_data  = i_cfg_data;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                decode_edge(t_opcode'(i_s_tuser), i_s_tdata);
                items_sent++;
                nxt_valid = 1'b0;
                drv_busy  = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                model_threshold = i_cfg_data;
                thresholds_written++;
                nxt_cfg_valid = 1'b0;
                drv_busy      = 1'b0;
            end
            if (!drv_busy && pending_requests.size() > 0) begin
                head = pending_requests[0];
                if (head.action == ACT_DRAIN) begin
                    quiet_cycles = (expected_readings.size() == 0) ? quiet_cycles + 1 : 0;
                    if (quiet_cycles >= SettleCycles) begin
                        void'(pending_requests.pop_front());
                        quiet_cycles = 0;
                    end
                end else if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    void'(pending_requests.pop_front());
                    drv_busy = 1'b1;
                    if (head.action == ACT_CONFIG) begin
                        nxt_cfg_valid = 1'b1;
                        nxt_cfg_data  = head.threshold;
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_user  = head.opcode;
                        nxt_data  = head.edge_time;
                    end
                    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, 9);
                end
            end
        end
        i_s_tvalid  <= nxt_valid;
        i_s_tuser   <= nxt_user;
        i_s_tdata   <= nxt_data;
        i_cfg_valid <= nxt_cfg_valid;
        i_cfg_data  <= nxt_cfg_data;
    end

    // Receiver: stalls at random and checks every reading against the oldest prediction.
    always @(posedge i_clk) begin
        t_reading got, want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.humidity      = o_m_tdata[15:0];
                got.temperature   = o_m_tdata[31:16];
                got.checksum_byte = o_m_tdata[39:32];
                got.checksum_ok   = o_m_tuser;
                readings_checked++;
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReports)
                        $display("Unexpected reading: hum %h temp %h sum %h ok %b",
                                 got.humidity, got.temperature, got.checksum_byte,
                                 got.checksum_ok);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.humidity !== want.humidity
                            || got.temperature !== want.temperature
                            || got.checksum_byte !== want.checksum_byte
                            || got.checksum_ok !== want.checksum_ok) begin
                        mismatch_count++;
                        if (mismatch_count <= MaxReports)
                            $display("Reading %0d: expected %h %h %h %b, got %h %h %h %b",
                                     readings_checked, want.humidity, want.temperature,
                                     want.checksum_byte, want.checksum_ok, got.humidity,
                                     got.temperature, got.checksum_byte, got.checksum_ok);
                    end
                end
                if ($urandom_range(0, 9) == 0) recv_calm = !recv_calm;
                recv_stall = recv_calm ? 0 : $urandom_range(0, 9);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
        end
        i_m_tready <= (recv_stall == 0);
    end

    task automatic push_item(input t_opcode op, input logic [TimeWidth-1:0] stamp);
        t_request r;
        r.action    = ACT_ITEM;
        r.opcode    = op;
        r.edge_time = stamp;
        r.threshold = '0;
        pending_requests.push_back(r);
        gen_items++;
    endtask

    task automatic push_threshold(input logic [ThresholdWidth-1:0] value);
        t_request r;
        r.action    = ACT_DRAIN;
        r.opcode    = OP_EDGE;
        r.edge_time = '0;
        r.threshold = value;
        pending_requests.push_back(r);
        r.action = ACT_CONFIG;
        pending_requests.push_back(r);
        gen_thr = value;
    endtask

    function automatic logic [TimeWidth-1:0] pick_interval(input logic data_bit);
        int unsigned thr;
        thr = gen_thr;
        if (!data_bit) begin
            case ($urandom_range(0, 3))
                0:       return thr;
                1:       return 0;
                default: return $urandom_range(0, thr);
            endcase
        end
        case ($urandom_range(0, 5))
            0:       return thr + 1;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(thr + 1, 32'hFFFF_FFFF);
            default: return $urandom_range(thr + 1, thr + 200);
        endcase
    endfunction

    // A start command, then edges 0 to stop_at-1 carrying the given bits, then stray edges.
    task automatic send_frame(input logic [FrameWidth-1:0] bits, input int stop_at,
                              input int stray);
        push_item(OP_START, $urandom);
        for (int k = 0; k < stop_at && k <= LastEdge; k++) begin
            if (k == 0)
                gen_time = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 900)
                                                        : gen_time + $urandom;
            else if (k < FirstDataEdge)
                gen_time = gen_time + $urandom_range(20, 200);
            else
                gen_time = gen_time + pick_interval(bits[LastEdge - k]);
            push_item(OP_EDGE, gen_time);
        end
        if (stop_at > LastEdge) gen_frames++;
        for (int k = 0; k < stray; k++) begin
            gen_time = gen_time + $urandom_range(0, 300);
            push_item(OP_EDGE, gen_time);
        end
    endtask

    function automatic logic [FrameWidth-1:0] random_frame();
        logic [7:0] b0, b1, b2, b3, b4;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        case ($urandom_range(0, 9))
            0: {b2, b3} = 16'h8000;
            1: {b0, b1, b2, b3} = 32'hFFFF_FFFF;
            2: {b0, b1, b2, b3} = 32'h0;
            default: ;
        endcase
        b4 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(b0 + b1 + b2 + b3);
        return {b0, b1, b2, b3, b4};
    endfunction

    initial begin
        int phase;
        int phase_items;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Edges before any start command, start commands back to back, extreme stamps.
        push_item(OP_EDGE, 32'h0000_0000);
        push_item(OP_EDGE, 32'hFFFF_FFFF);
        push_item(OP_EDGE, 32'h0000_0000);
        push_item(OP_EDGE, 32'hFFFF_FFFF);
        push_item(OP_EDGE, 32'h5555_5555);
        push_item(OP_EDGE, 32'hAAAA_AAAA);
        push_item(OP_START, 32'hFFFF_FFFF);
        push_item(OP_START, 32'h0000_0000);
        push_item(OP_EDGE, 32'h0000_0000);

        // Fixed frames: all zero, all one, negative zero temperature with stray edges, a negative
        // temperature with a bad checksum, a frame cut short, and a valid checksum.
        send_frame(40'h00_0000_0000, 43, 0);
        send_frame(40'hFF_FFFF_FFFF, 43, 2);
        send_frame(40'h02_9280_0014, 43, 5);
        send_frame(40'h02_8C80_6590, 43, 0);
        send_frame(40'h12_3456_789A, 20, 0);
        send_frame(40'h01_F400_E6DB, 43, 1);

        phase = 0;
        while (gen_items < 1600 || gen_frames < 30) begin
            case (phase)
                0:       push_threshold(16'd0);
                1:       push_threshold(16'hFFFF);
                2:       push_threshold(ThresholdReset);
                3:       push_threshold(16'd1);
                default: push_threshold(16'(($urandom_range(0, 1) == 0)
                                            ? $urandom_range(0, 400)
                                            : $urandom_range(0, 65535)));
            endcase
            phase++;
            phase_items = gen_items;
            while (gen_items - phase_items < 260) begin
                case ($urandom_range(0, 19))
                    0:       send_frame(random_frame(), $urandom_range(1, 42), 0);
                    1:       send_frame(random_frame(), 43, $urandom_range(1, 6));
                    2: begin
                        repeat ($urandom_range(1, 8))
                            push_item(t_opcode'($urandom_range(0, 3) == 0), $urandom);
                    end
                    default: send_frame(random_frame(), 43, 0);
                endcase
            end
        end
        push_threshold(ThresholdReset);
        send_frame(random_frame(), 43, 0);

        while (pending_requests.size() > 0 || drv_busy || expected_readings.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        $display("Sent %0d items in %0d frames under %0d threshold settings.",
                 items_sent, gen_frames, thresholds_written + 1);
        $display("Checked %0d readings against the predicted values.", readings_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d readings outstanding.", expected_readings.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
